>>> src/kcc_pkg.sv
package kcc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH = 16;
	localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
	localparam int PHASE_WIDTH = 3;
	localparam int EVENT_WIDTH = 3;
	localparam int REG_INDEX_WIDTH = 2;

	localparam logic [PHASE_WIDTH-1:0] PH_IDLE = 3'd0;
	localparam logic [PHASE_WIDTH-1:0] PH_DOWN = 3'd1;
	localparam logic [PHASE_WIDTH-1:0] PH_UP = 3'd2;
	localparam logic [PHASE_WIDTH-1:0] PH_LONG = 3'd3;
	localparam logic [PHASE_WIDTH-1:0] PH_SECOND_DOWN = 3'd4;
	localparam logic [PHASE_WIDTH-1:0] PH_DOUBLE_UP = 3'd5;
	localparam logic [PHASE_WIDTH-1:0] PH_TRIPLE = 3'd6;

	localparam logic [EVENT_WIDTH-1:0] EV_NONE = 3'd0;
	localparam logic [EVENT_WIDTH-1:0] EV_SINGLE = 3'd1;
	localparam logic [EVENT_WIDTH-1:0] EV_DOUBLE = 3'd2;
	localparam logic [EVENT_WIDTH-1:0] EV_TRIPLE = 3'd3;
	localparam logic [EVENT_WIDTH-1:0] EV_LONG = 3'd4;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_LONG_PRESS_TICKS = 2'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_GAP_MAX_TICKS = 2'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_GAP_MIN_TICKS = 2'd2;

	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TICKS_RESET = 16'd100;
	localparam logic [CFG_WIDTH-1:0] GAP_MAX_TICKS_RESET = 16'd30;
	localparam logic [CFG_WIDTH-1:0] GAP_MIN_TICKS_RESET = 16'd2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam logic PIN_PRESSED = 1'b0;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [CFG_WIDTH-1:0] cfg_word_t;
	typedef logic [PHASE_WIDTH-1:0] phase_t;
	typedef logic [EVENT_WIDTH-1:0] event_t;

	typedef struct packed {
		logic command;
		logic pin_level;
	} item_t;

	typedef struct packed {
		event_t event_code;
		logic event_valid;
	} result_t;

	typedef struct packed {
		cfg_word_t long_press_ticks;
		cfg_word_t gap_max_ticks;
		cfg_word_t gap_min_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t click_phase;
		event_t pending_event;
	} core_status_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
	endfunction

	function automatic logic reached(input count_t v, input cfg_word_t limit);
		return CMP_WIDTH'(v) >= CMP_WIDTH'(limit);
	endfunction

	function automatic logic in_window(input count_t v, input cfg_t cfg);
		return (CMP_WIDTH'(v) >= CMP_WIDTH'(cfg.gap_min_ticks))
			&& (CMP_WIDTH'(v) <= CMP_WIDTH'(cfg.gap_max_ticks));
	endfunction

endpackage

>>> src/kcc_if.sv
interface kcc_item_if;
	import kcc_pkg::*;

	logic valid;
	logic ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface kcc_result_if;
	import kcc_pkg::*;

	logic valid;
	logic ready;
	result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> src/kcc_cfg_regs.sv
module kcc_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [kcc_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
	input logic [kcc_pkg::CFG_WIDTH-1:0] cfg_data,
	output kcc_pkg::cfg_t cfg
);
	import kcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_PRESS_TICKS_RESET;
			cfg_q.gap_max_ticks <= GAP_MAX_TICKS_RESET;
			cfg_q.gap_min_ticks <= GAP_MIN_TICKS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data;
				REG_GAP_MAX_TICKS: cfg_q.gap_max_ticks <= cfg_data;
				REG_GAP_MIN_TICKS: cfg_q.gap_min_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> src/kcc_core.sv
module kcc_core (
	input logic clk,
	input logic arst_n,
	input logic step,
	input kcc_pkg::item_t item,
	input kcc_pkg::cfg_t cfg,
	output kcc_pkg::result_t result,
	output kcc_pkg::core_status_t status
);
	import kcc_pkg::*;

	phase_t phase_q, phase_d;
	event_t pending_q, pending_d;
	count_t hold_q, hold_d;
	count_t gap_q, gap_d;
	count_t first_gap_q, first_gap_d;
	count_t second_gap_q, second_gap_d;

	always_comb begin
		phase_d = phase_q;
		pending_d = pending_q;
		hold_d = hold_q;
		gap_d = gap_q;
		first_gap_d = first_gap_q;
		second_gap_d = second_gap_q;
		result.event_code = EV_NONE;
		result.event_valid = 1'b0;

		if (item.command == CMD_READ) begin
			if (pending_q != EV_NONE) begin
				result.event_code = pending_q;
				result.event_valid = 1'b1;
				pending_d = EV_NONE;
				phase_d = PH_IDLE;
			end
		end else begin
			if (item.pin_level == PIN_PRESSED) begin
				case (phase_q)
					PH_IDLE: phase_d = PH_DOWN;
					PH_DOWN: begin
						hold_d = sat_inc(hold_q);
						if (reached(hold_d, cfg.long_press_ticks)) begin
							pending_d = EV_LONG;
							phase_d = PH_LONG;
						end
					end
					PH_UP: begin
						phase_d = PH_SECOND_DOWN;
						gap_d = '0;
					end
					PH_DOUBLE_UP: phase_d = PH_TRIPLE;
					default: ;
				endcase
			end else begin
				case (phase_q)
					PH_IDLE: begin
						hold_d = '0;
						gap_d = '0;
						first_gap_d = '0;
						second_gap_d = '0;
					end
					PH_DOWN: phase_d = PH_UP;
					PH_UP: begin
						gap_d = sat_inc(gap_q);
						first_gap_d = sat_inc(first_gap_q);
						if (reached(gap_d, cfg.gap_max_ticks)) begin
							pending_d = EV_SINGLE;
							phase_d = PH_IDLE;
						end
					end
					PH_SECOND_DOWN: phase_d = PH_DOUBLE_UP;
					PH_DOUBLE_UP: begin
						gap_d = sat_inc(gap_q);
						second_gap_d = sat_inc(second_gap_q);
						if (reached(gap_d, cfg.gap_max_ticks)) begin
							if (in_window(first_gap_q, cfg)) begin
								pending_d = EV_DOUBLE;
							end
							phase_d = PH_IDLE;
						end
					end
					PH_TRIPLE: begin
						if (in_window(second_gap_q, cfg)) begin
							pending_d = EV_TRIPLE;
						end
						phase_d = PH_IDLE;
					end
					default: ;
				endcase
			end
			result.event_code = pending_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pending_q <= EV_NONE;
			hold_q <= '0;
			gap_q <= '0;
			first_gap_q <= '0;
			second_gap_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pending_q <= pending_d;
			hold_q <= hold_d;
			gap_q <= gap_d;
			first_gap_q <= first_gap_d;
			second_gap_q <= second_gap_d;
		end
	end

	assign status.click_phase = phase_q;
	assign status.pending_event = pending_q;
endmodule

>>> src/key_click_classifier.sv
// Classifies one active-low push button into single, double, triple or long press from a stream
// of beats: a sample beat carries the pin level of one tick, a read beat returns and clears the
// pending event. Every beat gives exactly one result beat. One beat is taken in every cycle while
// the result side keeps up. A beat is first held in the input register while the state update
// logic works out its result, which is then loaded into the result register and offered from
// there as soon as the result side can take it. A result beat that is held back stalls the
// state update, and the input stops taking beats once both registers are full. Thresholds are
// written through the configuration port and should only change while no beat is in flight.
module key_click_classifier (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [kcc_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
	input logic [kcc_pkg::CFG_WIDTH-1:0] cfg_data,
	kcc_item_if.sink item,
	kcc_result_if.source result
);
	import kcc_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	item_t item_s1;
	logic result_valid_q;
	result_t result_q;
	result_t core_result;
	core_status_t status;
	logic advance;
	logic step;

	assign advance = !result_valid_q || result.ready;
	assign step = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	kcc_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	kcc_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.cfg(cfg),
		.result(core_result),
		.status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= core_result;
		end
	end

	assign result.valid = result_valid_q;
	assign result.payload = result_q;

	a_ready_only_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (result_valid_q && !result.ready))
		else $error("input stalled without a blocked result");

	a_valid_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.event_valid) |-> (result_q.event_code != EV_NONE))
		else $error("returned event flagged valid with no code");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.command == CMD_READ) |=> (status.pending_event == EV_NONE))
		else $error("read left an event pending");

	a_read_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.command == CMD_READ && status.pending_event != EV_NONE)
		|=> (status.click_phase == PH_IDLE))
		else $error("read of an event did not return to idle");
endmodule
